### design/io_apic_indirect_register_file_top_defines.svh
// assertion macros for the io apic register window
// used by io_apic_indirect_register_file_top, expects clk_i and rst_ni in scope
`ifndef IO_APIC_INDIRECT_REGISTER_FILE_TOP_DEFINES_SVH
`define IO_APIC_INDIRECT_REGISTER_FILE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IOAPIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define IOAPIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ioapic_pkg.sv
// shared types and constants of the io apic register window
// no dependencies
package ioapic_pkg;

  // configuration defaults
  localparam int unsigned DefaultEntries = 24;
  localparam logic [7:0]  VersionReset   = 8'd17;

  // access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // window offsets
  localparam logic [4:0] OFS_INDEX = 5'h00;
  localparam logic [4:0] OFS_DATA  = 5'h10;

  // register indexes
  localparam logic [7:0] REG_ID    = 8'h00;
  localparam logic [7:0] REG_VER   = 8'h01;
  localparam logic [7:0] REG_ARB   = 8'h02;
  localparam logic [7:0] REG_TABLE = 8'h10;

  // low half of an entry
  localparam int unsigned LowW      = 17;
  localparam logic [LowW-1:0] LowWritable = 17'h1AFFF;
  localparam logic [LowW-1:0] LowReset    = 17'h10000;

  // entry number as carried in the decode result
  localparam int unsigned EntNumW = 7;

  // decode of one access against the current index
  typedef struct packed {
    logic                 index_acc;
    logic                 data_acc;
    logic                 reg_id;
    logic                 reg_ver;
    logic                 reg_arb;
    logic                 tbl_low;
    logic                 tbl_high;
    logic [EntNumW-1:0]   entry;
  } dec_t;

endpackage

### design/ioapic_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module ioapic_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/ioapic_decode.sv
// address decode of a window access against the index register
// depends on ioapic_pkg
module ioapic_decode #(
  parameter int unsigned Entries = 24
) (
  input  logic [7:0]        index_i,
  input  logic [4:0]        offset_i,
  output ioapic_pkg::dec_t  dec_o
);
  import ioapic_pkg::*;

  logic [7:0]         rel;
  logic [EntNumW-1:0] ent;
  logic               in_tbl;

  // table entry and half from the index
  assign rel    = index_i - REG_TABLE;
  assign ent    = rel[7:1];
  assign in_tbl = (index_i >= REG_TABLE) && (ent < EntNumW'(Entries));

  always_comb begin
    dec_o           = '0;
    dec_o.index_acc = (offset_i == OFS_INDEX);
    dec_o.data_acc  = (offset_i == OFS_DATA);
    dec_o.reg_id    = (index_i == REG_ID);
    dec_o.reg_ver   = (index_i == REG_VER);
    dec_o.reg_arb   = (index_i == REG_ARB);
    dec_o.tbl_low   = in_tbl && !rel[0];
    dec_o.tbl_high  = in_tbl && rel[0];
    dec_o.entry     = ent;
  end

endmodule

### design/io_apic_indirect_register_file_top.sv
// top level of the io apic register window: index register, id, version and
// the redirection table in two rams; depends on ioapic_pkg, ioapic_decode, ioapic_ram
//
// Usage:
// - input channel (in_valid_i / in_stall_o) carries one bus access per item:
//   command_i (read or write), offset_i (0 index register, 16 data window)
//   and write_data_i
// - output channel (out_valid_o / out_stall_i) returns one item per access,
//   read_data_o, zero for writes and unmapped registers or offsets
// - configuration channel (cfg_valid_i / cfg_ready_o) sets the version byte;
//   cfg_ready_o is always high, write it only while no access is in flight
// - results pass through the read stage and the output register; a new access is taken
//   every cycle while in_stall_o is low, the table rams having a registered read
// - writes land at the accept edge, a following read sees them at once
// - when the receiver stalls the result holds in the output register, one
//   more access waits in the read stage, then in_stall_o rises
// - reset clears index, id and the per-entry valid bits and sets the version
//   byte to 17; an entry never written reads as masked with all other fields
//   zero, so no clearing pass is needed
`include "io_apic_indirect_register_file_top_defines.svh"

module io_apic_indirect_register_file_top #(
  parameter int unsigned Entries = ioapic_pkg::DefaultEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [4:0]  offset_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  version_byte_i
);
  import ioapic_pkg::*;

  localparam int unsigned AddrW = (Entries > 1) ? $clog2(Entries) : 1;

  dec_t              dec;
  logic              acc;
  logic              is_wr;
  logic              is_rd;
  logic [AddrW-1:0]  addr;
  logic              low_we;
  logic              dest_we;
  logic              low_re;
  logic              dest_re;
  logic [LowW-1:0]   low_rdata;
  logic [7:0]        dest_rdata;
  logic [31:0]       direct_data;
  logic              out_load;
  logic [31:0]       result;

  logic [7:0]         index_q, index_d;
  logic [3:0]         apic_id_q, apic_id_d;
  logic [7:0]         version_q, version_d;
  logic [Entries-1:0] low_vld_q, low_vld_d;
  logic [Entries-1:0] dest_vld_q, dest_vld_d;
  logic               s1_valid_q, s1_valid_d;
  logic               s1_low_q, s1_high_q, s1_vld_q;
  logic [31:0]        s1_data_q;
  logic               out_valid_q, out_valid_d;
  logic [31:0]        read_data_q;

  // decode against the current index
  ioapic_decode #(
    .Entries (Entries)
  ) u_decode (
    .index_i  (index_q),
    .offset_i (offset_i),
    .dec_o    (dec)
  );

  // handshake
  assign out_load   = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !out_load;
  assign acc        = in_valid_i && !in_stall_o;
  assign is_wr      = (command_i == CMD_WRITE);
  assign is_rd      = (command_i == CMD_READ);
  assign addr       = dec.entry[AddrW-1:0];
  assign cfg_ready_o = 1'b1;

  // table ram strobes
  assign low_we  = acc && dec.data_acc && dec.tbl_low  && is_wr;
  assign dest_we = acc && dec.data_acc && dec.tbl_high && is_wr;
  assign low_re  = acc && dec.data_acc && dec.tbl_low  && is_rd;
  assign dest_re = acc && dec.data_acc && dec.tbl_high && is_rd;

  ioapic_ram #(
    .Width (LowW),
    .Depth (Entries),
    .AddrW (AddrW)
  ) u_low_ram (
    .clk_i   (clk_i),
    .we_i    (low_we),
    .waddr_i (addr),
    .wdata_i (write_data_i[LowW-1:0] & LowWritable),
    .re_i    (low_re),
    .raddr_i (addr),
    .rdata_o (low_rdata)
  );

  ioapic_ram #(
    .Width (8),
    .Depth (Entries),
    .AddrW (AddrW)
  ) u_dest_ram (
    .clk_i   (clk_i),
    .we_i    (dest_we),
    .waddr_i (addr),
    .wdata_i (write_data_i[31:24]),
    .re_i    (dest_re),
    .raddr_i (addr),
    .rdata_o (dest_rdata)
  );

  // read data not held in the rams, taken at accept
  always_comb begin
    direct_data = '0;
    if (is_rd && dec.index_acc) begin
      direct_data = {24'h0, index_q};
    end else if (is_rd && dec.data_acc && (dec.reg_id || dec.reg_arb)) begin
      direct_data = {4'h0, apic_id_q, 24'h0};
    end else if (is_rd && dec.data_acc && dec.reg_ver) begin
      direct_data = {8'h0, 8'(Entries - 1), 8'h0, version_q};
    end
  end

  // register updates
  always_comb begin
    index_d    = index_q;
    apic_id_d  = apic_id_q;
    version_d  = version_q;
    low_vld_d  = low_vld_q;
    dest_vld_d = dest_vld_q;
    if (acc && is_wr && dec.index_acc) begin
      index_d = write_data_i[7:0];
    end
    if (acc && is_wr && dec.data_acc && dec.reg_id) begin
      apic_id_d = write_data_i[27:24];
    end
    if (cfg_valid_i && cfg_ready_o) begin
      version_d = version_byte_i;
    end
    if (low_we) begin
      low_vld_d[addr] = 1'b1;
    end
    if (dest_we) begin
      dest_vld_d[addr] = 1'b1;
    end
  end

  // stage and output valid
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (acc) begin
      s1_valid_d = 1'b1;
    end else if (out_load) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q     <= '0;
      apic_id_q   <= '0;
      version_q   <= VersionReset;
      low_vld_q   <= '0;
      dest_vld_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      index_q     <= index_d;
      apic_id_q   <= apic_id_d;
      version_q   <= version_d;
      low_vld_q   <= low_vld_d;
      dest_vld_q  <= dest_vld_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_low_q  <= low_re;
      s1_high_q <= dest_re;
      s1_vld_q  <= dec.tbl_low ? low_vld_q[addr] : dest_vld_q[addr];
      s1_data_q <= direct_data;
    end
  end

  // merge ram data, unwritten entries read as reset value
  always_comb begin
    result = s1_data_q;
    if (s1_low_q) begin
      result = {15'h0, s1_vld_q ? low_rdata : LowReset};
    end else if (s1_high_q) begin
      result = {s1_vld_q ? dest_rdata : 8'h0, 24'h0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      read_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  // checks
  `IOAPIC_ASSERT_NEXT(a_ram_read_tracked, low_re || dest_re,
      s1_valid_q && (s1_low_q || s1_high_q), "table read not tracked in read stage")
  `IOAPIC_ASSERT_NEXT(a_low_write_valid, low_we, low_vld_q[$past(addr)],
      "written low entry not marked valid")
  `IOAPIC_ASSERT_NOW(a_result_from_stage, $rose(out_valid_q), $past(s1_valid_q),
      "result appeared without an access in the read stage")

endmodule
